FILE: design/b64sd_pkg.sv
// Package for the base64 stream decoder.
// Holds status codes, the record passed from front to back, and the
// character classification helpers. No dependencies.
package b64sd_pkg;

    // Status codes carried on the status port
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR   = 2'd1;
    localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Alphabet offsets
    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // One unit of work for the back end: either up to three packed bytes,
    // or a single closing word that carries a status
    typedef struct packed {
        logic        is_close;
        logic [1:0]  status;
        logic [1:0]  count;     // bytes to emit, 1..3; 1 for a close
        logic        eot;
        logic [23:0] bytes;     // first byte in [23:16]
    } job_t;

    // Whitespace: space and 0x09..0x0D
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Map a character to its 6-bit value; bit 6 flags a non-alphabet character
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A)
            r = {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A)
            r = {1'b0, 6'(c - 8'h61) + SEXTET_LOWER_BASE};
        else if (c >= 8'h30 && c <= 8'h39)
            r = {1'b0, 6'(c - 8'h30) + SEXTET_DIGIT_BASE};
        else if (c == 8'h2B)
            r = {1'b0, SEXTET_PLUS};
        else if (c == 8'h2F)
            r = {1'b0, SEXTET_SLASH};
        return r;
    endfunction

endpackage

FILE: design/b64sd_front.sv
// Front end of the base64 stream decoder: classifies each character,
// gathers groups of four and builds one job word per result-causing item.
// Depends on b64sd_pkg.
module b64sd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        char_in,
    input  logic              end_of_text,
    output logic              job_valid,
    output b64sd_pkg::job_t   job
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        tip_reg, tip_next;
    logic [1:0]  err_reg, err_next;

    logic        blank;
    logic        pad;
    logic [6:0]  sx;
    logic [5:0]  val;
    logic        bad;
    logic [23:0] shifted;
    logic [23:0] acc_full;
    logic        tip_now;

    // Classify the incoming character
    always_comb
    begin
        blank = b64sd_pkg::is_blank(char_in);
        pad   = (char_in == b64sd_pkg::CHAR_PAD);
        sx    = b64sd_pkg::sextet_of(char_in);
        val   = pad ? 6'd0 : sx[5:0];
        bad   = (pad && (pos_reg == 2'd0 || pos_reg == 2'd1)) || (!pad && sx[6]);
        case (pos_reg)
            2'd0:    shifted = {val, 18'd0};
            2'd1:    shifted = {6'd0, val, 12'd0};
            2'd2:    shifted = {12'd0, val, 6'd0};
            default: shifted = {18'd0, val};
        endcase
        acc_full = {acc_reg, 6'd0} | shifted;
        tip_now  = (pos_reg == 2'd2) ? pad : tip_reg;
    end

    // Decide the job word and the next group state
    always_comb
    begin
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        tip_next  = tip_reg;
        err_next  = err_reg;
        job_valid = 1'b0;
        job.is_close = 1'b1;
        job.status   = b64sd_pkg::STATUS_OK;
        job.count    = 2'd1;
        job.eot      = 1'b1;
        job.bytes    = 24'd0;

        if (err_reg != b64sd_pkg::STATUS_OK) begin
            job.status = err_reg;
            job_valid  = end_of_text;
        end else if (blank) begin
            job.status = (pos_reg != 2'd0) ? b64sd_pkg::STATUS_BAD_LENGTH
                                           : b64sd_pkg::STATUS_OK;
            job_valid  = end_of_text;
        end else if (bad) begin
            job.status = b64sd_pkg::STATUS_BAD_CHAR;
            job_valid  = end_of_text;
            err_next   = b64sd_pkg::STATUS_BAD_CHAR;
        end else if (pos_reg != 2'd3) begin
            job.status = b64sd_pkg::STATUS_BAD_LENGTH;
            job_valid  = end_of_text;
            pos_next   = pos_reg + 2'd1;
            acc_next   = acc_full[23:6];
            tip_next   = tip_now;
        end else begin
            // Group complete: pack the bytes to emit, skipping padded ones
            job_valid    = 1'b1;
            job.is_close = 1'b0;
            job.eot      = end_of_text;
            job.count    = 2'd1 + {1'b0, !tip_now} + {1'b0, !pad};
            job.bytes    = {acc_full[23:16],
                            tip_now ? acc_full[7:0] : acc_full[15:8],
                            acc_full[7:0]};
            pos_next     = 2'd0;
            acc_next     = 18'd0;
            tip_next     = 1'b0;
        end

        // Clear everything at the end of the text
        if (end_of_text) begin
            pos_next = 2'd0;
            acc_next = 18'd0;
            tip_next = 1'b0;
            err_next = b64sd_pkg::STATUS_OK;
        end
    end

    // Hold group state between words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= 2'd0;
            acc_reg <= 18'd0;
            tip_reg <= 1'b0;
            err_reg <= b64sd_pkg::STATUS_OK;
        end else if (take) begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            tip_reg <= tip_next;
            err_reg <= err_next;
        end
    end

endmodule

FILE: design/b64sd_fifo.sv
// Small register queue that decouples the decoder's front and back ends.
// Generic in width and depth; no package dependencies.
module b64sd_fifo
#(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    // Store incoming word
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/b64sd_back.sv
// Back end of the base64 stream decoder: takes job words from the queue and
// presents their results one word per cycle, while pop is held, on the output side.
// Depends on b64sd_pkg.
module b64sd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_ready,
    input  b64sd_pkg::job_t   job,
    output logic              job_take,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              run_last,
    output logic              text_done,
    output logic [1:0]        status
);

    b64sd_pkg::job_t cur_reg;
    logic            valid_reg;
    logic [1:0]      idx_reg;
    logic            last;

    assign last     = (idx_reg == cur_reg.count - 2'd1);
    assign job_take = job_ready && (!valid_reg || (pop && last));

    // Drive the current result word
    always_comb
    begin
        empty      = !valid_reg;
        byte_valid = !cur_reg.is_close;
        run_last   = last;
        text_done  = last && cur_reg.eot;
        status     = cur_reg.is_close ? cur_reg.status : b64sd_pkg::STATUS_OK;
        case (idx_reg)
            2'd0:    out_byte = cur_reg.bytes[23:16];
            2'd1:    out_byte = cur_reg.bytes[15:8];
            default: out_byte = cur_reg.bytes[7:0];
        endcase
        if (cur_reg.is_close)
            out_byte = 8'd0;
    end

    // Load a new job or step through the bytes of the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (job_take) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (pop && valid_reg) begin
            if (last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // Hold the job payload
    always_ff @(posedge clk)
    begin
        if (job_take)
            cur_reg <= job;
    end

endmodule

FILE: design/base64_stream_decoder.sv
// Base64 stream decoder: one character word accepted per cycle while the queue has room, bytes out.
// A result-causing character's job word passes through a queue slot and then the back end's job register.
// Throughput: one character per cycle unless full; results leave at one word per cycle,
// so a group's three bytes take three pops; the queue absorbs the difference.
// Reset (rst_n low, asynchronous) empties the queue and clears group state.
// Depends on b64sd_pkg, b64sd_front, b64sd_fifo and b64sd_back.
module base64_stream_decoder
#(
    parameter int QUEUE_DEPTH = b64sd_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       text_done,
    output logic [1:0] status
);

    localparam int JOB_W = $bits(b64sd_pkg::job_t);

    logic            take;
    logic            job_valid;
    b64sd_pkg::job_t front_job;
    b64sd_pkg::job_t head_job;
    logic            q_full;
    logic            q_not_empty;
    logic            q_take;

    // Accept a character whenever the queue has room
    assign full = q_full;
    assign take = push && !q_full;

    b64sd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .job_valid   (job_valid),
        .job         (front_job)
    );

    b64sd_fifo
    #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (take && job_valid),
        .wr_data   (front_job),
        .rd_en     (q_take),
        .rd_data   (head_job),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    b64sd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_ready  (q_not_empty),
        .job        (head_job),
        .job_take   (q_take),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .text_done  (text_done),
        .status     (status)
    );

endmodule

FILE: design/b64sd_checker.sv
// Port-level checker for the base64 stream decoder, bound to the top level.
// Depends on b64sd_pkg.
module b64sd_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_byte,
    input  logic       byte_valid,
    input  logic       run_last,
    input  logic       text_done,
    input  logic [1:0] status
);

    // Hold a waiting result word until it is popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(byte_valid)))
        else $error("result word changed while waiting");

    // A closing word ends both the item and the text
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !byte_valid) |-> (run_last && text_done))
        else $error("closing word without run_last and text_done");

    // Byte words always carry ok status
    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && byte_valid) |-> (status == b64sd_pkg::STATUS_OK))
        else $error("byte word with error status");

    // Text end implies item end
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_done) |-> run_last)
        else $error("text_done without run_last");

    // A non-last word is followed by more of the same item
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !run_last) |=> (!empty && byte_valid))
        else $error("missing follow-on byte word");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (.*);
